@@ design/isfp_pkg.sv @@
// ----------------------------------------------------------------------------
// isfp_pkg
// Shared types and constants of the idle-delimited sensor frame parser.
// ----------------------------------------------------------------------------
package isfp_pkg;

  localparam int BUFFER_LIMIT = 128;
  localparam int POS_W        = 8;

  localparam logic [POS_W-1:0] FRAME_BYTES  = POS_W'(54);
  localparam logic [POS_W-1:0] POS_ID_LO    = POS_W'(0);
  localparam logic [POS_W-1:0] POS_ID_HI    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_ROLL_LO  = POS_W'(34);
  localparam logic [POS_W-1:0] POS_ROLL_HI  = POS_W'(35);
  localparam logic [POS_W-1:0] POS_PITCH_LO = POS_W'(36);
  localparam logic [POS_W-1:0] POS_PITCH_HI = POS_W'(37);
  localparam logic [POS_W-1:0] POS_VER_LO   = POS_W'(50);
  localparam logic [POS_W-1:0] POS_VER_HI   = POS_W'(51);
  localparam logic [POS_W-1:0] POS_TRL_LO   = POS_W'(52);
  localparam logic [POS_W-1:0] POS_TRL_HI   = POS_W'(53);
  localparam logic [POS_W-1:0] POS_LIMIT    = POS_W'(BUFFER_LIMIT);

  // 'W' first, then 'T'; 0x0D first, then 0x0A (little-endian words).
  localparam logic [15:0] ID_WORD      = 16'h5457;
  localparam logic [15:0] TRAILER_WORD = 16'h0A0D;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_IDLE = 1'b1;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_LENGTH  = 3'd1;
  localparam logic [2:0] ST_BAD_ID      = 3'd2;
  localparam logic [2:0] ST_BAD_TRAILER = 3'd3;
  localparam logic [2:0] ST_BAD_VERSION = 3'd4;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [15:0] roll_raw;
    logic signed [15:0] pitch_raw;
    logic [31:0]        frames_seen;
    logic [31:0]        frames_valid;
  } isfp_result_t;

endpackage

@@ design/isfp_capture.sv @@
// ----------------------------------------------------------------------------
// isfp_capture
// Frame position tracking, field capture, frame checks and counters.
// ----------------------------------------------------------------------------
module isfp_capture
  import isfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic [15:0]  expected_version,
  input  logic         item_take,
  input  logic         req_type,
  input  logic [7:0]   rx_byte,
  output logic         res_push,
  output isfp_result_t res
);

  logic [POS_W-1:0] byte_count_r, byte_count_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] roll_r, roll_nxt;
  logic [15:0] pitch_r, pitch_nxt;
  logic [15:0] ver_r, ver_nxt;
  logic [15:0] trl_r, trl_nxt;
  logic [31:0] frame_cnt_r, frame_cnt_nxt;
  logic [31:0] valid_cnt_r, valid_cnt_nxt;
  logic [2:0]  status;
  logic        is_byte;
  logic        is_close;

  assign is_byte  = item_take && (req_type == REQ_BYTE) && (byte_count_r < POS_LIMIT);
  assign is_close = item_take && (req_type == REQ_IDLE) && (byte_count_r != '0);

  always_comb begin
    if (byte_count_r != FRAME_BYTES) begin
      status = ST_BAD_LENGTH;
    end else if (id_r != ID_WORD) begin
      status = ST_BAD_ID;
    end else if (trl_r != TRAILER_WORD) begin
      status = ST_BAD_TRAILER;
    end else if (ver_r != expected_version) begin
      status = ST_BAD_VERSION;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    id_nxt         = id_r;
    roll_nxt       = roll_r;
    pitch_nxt      = pitch_r;
    ver_nxt        = ver_r;
    trl_nxt        = trl_r;
    frame_cnt_nxt  = frame_cnt_r;
    valid_cnt_nxt  = valid_cnt_r;
    if (is_byte) begin
      byte_count_nxt = byte_count_r + POS_W'(1);
      case (byte_count_r)
        POS_ID_LO:    id_nxt[7:0]     = rx_byte;
        POS_ID_HI:    id_nxt[15:8]    = rx_byte;
        POS_ROLL_LO:  roll_nxt[7:0]   = rx_byte;
        POS_ROLL_HI:  roll_nxt[15:8]  = rx_byte;
        POS_PITCH_LO: pitch_nxt[7:0]  = rx_byte;
        POS_PITCH_HI: pitch_nxt[15:8] = rx_byte;
        POS_VER_LO:   ver_nxt[7:0]    = rx_byte;
        POS_VER_HI:   ver_nxt[15:8]   = rx_byte;
        POS_TRL_LO:   trl_nxt[7:0]    = rx_byte;
        POS_TRL_HI:   trl_nxt[15:8]   = rx_byte;
        default: ;
      endcase
    end
    if (is_close) begin
      byte_count_nxt = '0;
      frame_cnt_nxt  = frame_cnt_r + 32'd1;
      if (status == ST_OK) begin
        valid_cnt_nxt = valid_cnt_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      id_r         <= '0;
      roll_r       <= '0;
      pitch_r      <= '0;
      ver_r        <= '0;
      trl_r        <= '0;
      frame_cnt_r  <= '0;
      valid_cnt_r  <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      id_r         <= id_nxt;
      roll_r       <= roll_nxt;
      pitch_r      <= pitch_nxt;
      ver_r        <= ver_nxt;
      trl_r        <= trl_nxt;
      frame_cnt_r  <= frame_cnt_nxt;
      valid_cnt_r  <= valid_cnt_nxt;
    end
  end

  // Roll and pitch are only reported for frames that pass every check.
  always_comb begin
    res.status       = status;
    res.roll_raw     = (status == ST_OK) ? roll_r : 16'sd0;
    res.pitch_raw    = (status == ST_OK) ? pitch_r : 16'sd0;
    res.frames_seen  = frame_cnt_nxt;
    res.frames_valid = valid_cnt_nxt;
  end

  assign res_push = is_close;

endmodule

@@ design/idle_delimited_sensor_frame_parser.sv @@
// ----------------------------------------------------------------------------
// idle_delimited_sensor_frame_parser
// Parses idle-delimited sensor frames from a received UART byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): each item is either a received byte
//   (in_req_type 0) or a line-idle event (in_req_type 1). One item can be
//   taken every clock cycle while in_stall is low.
//   Result channel (out_valid / out_stall): an idle event that follows at
//   least one byte closes the frame and yields one result item with the check
//   status, raw roll and pitch and the two frame counters. Bytes and idle
//   events on an empty frame yield nothing.
//   The result of an idle event is computed combinationally and registered
//   in the output queue. Throughput is one item per cycle while in_stall is
//   low, set by the single capture and check stage.
//   A two-entry output queue (result register plus skid register) keeps the
//   input flowing while the receiver stalls; in_stall rises only when both
//   entries hold results.
//   cfg_wr_en writes the expected version word; it is meant to change only
//   while the block is idle.
//   Reset (rst_n low, synchronous) clears the frame position, the captured
//   fields, both counters, the expected version and the output queue.
// ----------------------------------------------------------------------------
module idle_delimited_sensor_frame_parser
  import isfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [0:0]         in_req_type,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic signed [15:0] out_roll_raw,
  output logic signed [15:0] out_pitch_raw,
  output logic [31:0]        out_frames_seen,
  output logic [31:0]        out_frames_valid
);

  logic [15:0]  exp_ver_r;
  logic         item_take;
  logic         res_push;
  isfp_result_t res;
  logic         out_valid_r;
  logic         skid_valid_r;
  isfp_result_t out_data_r;
  isfp_result_t skid_data_r;
  logic         out_free;

  assign in_stall  = skid_valid_r;
  assign item_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ver_r <= '0;
    end else if (cfg_wr_en) begin
      exp_ver_r <= cfg_wr_data;
    end
  end

  isfp_capture u_capture (
    .clk              (clk),
    .rst_n            (rst_n),
    .expected_version (exp_ver_r),
    .item_take        (item_take),
    .req_type         (in_req_type[0]),
    .rx_byte          (in_rx_byte),
    .res_push         (res_push),
    .res              (res)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= res_push;
      end else begin
        out_valid_r  <= res_push;
      end
    end else if (res_push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r  <= skid_data_r;
        skid_data_r <= res;
      end else begin
        out_data_r  <= res;
      end
    end else if (res_push) begin
      skid_data_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_data_r.status;
  assign out_roll_raw     = out_data_r.roll_raw;
  assign out_pitch_raw    = out_data_r.pitch_raw;
  assign out_frames_seen  = out_data_r.frames_seen;
  assign out_frames_valid = out_data_r.frames_valid;

endmodule

@@ tb/sv/isfp_frame_checker.sv @@
// ----------------------------------------------------------------------------
// isfp_frame_checker
// Watches both channels of the frame parser, predicts each frame result from
// the accepted items and compares it with what the block delivers.
// ----------------------------------------------------------------------------
module isfp_frame_checker
  import isfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [0:0]         in_req_type,
  input  logic [7:0]         in_rx_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         out_status,
  input  logic signed [15:0] out_roll_raw,
  input  logic signed [15:0] out_pitch_raw,
  input  logic [31:0]        out_frames_seen,
  input  logic [31:0]        out_frames_valid,
  output int                 errors,
  output int                 pending
);

  logic [POS_W-1:0] frame_pos;
  logic [15:0]      id_word;
  logic [15:0]      roll_word;
  logic [15:0]      pitch_word;
  logic [15:0]      ver_word;
  logic [15:0]      trl_word;
  logic [31:0]      seen_count;
  logic [31:0]      valid_count;
  logic [15:0]      want_version;

  isfp_result_t frame_results_q[$];
  isfp_result_t want;
  isfp_result_t got;

  // Update the frame state with one accepted item; a closing idle queues
  // the result that the block must produce.
  function automatic void absorb_item(logic req, logic [7:0] b);
    isfp_result_t r;
    if (req == REQ_BYTE) begin
      if (frame_pos < POS_LIMIT) begin
        case (frame_pos)
          POS_ID_LO:    id_word[7:0]     = b;
          POS_ID_HI:    id_word[15:8]    = b;
          POS_ROLL_LO:  roll_word[7:0]   = b;
          POS_ROLL_HI:  roll_word[15:8]  = b;
          POS_PITCH_LO: pitch_word[7:0]  = b;
          POS_PITCH_HI: pitch_word[15:8] = b;
          POS_VER_LO:   ver_word[7:0]    = b;
          POS_VER_HI:   ver_word[15:8]   = b;
          POS_TRL_LO:   trl_word[7:0]    = b;
          POS_TRL_HI:   trl_word[15:8]   = b;
          default: ;
        endcase
        frame_pos = frame_pos + POS_W'(1);
      end
    end else if (frame_pos != '0) begin
      seen_count = seen_count + 32'd1;
      if (frame_pos != FRAME_BYTES)
        r.status = ST_BAD_LENGTH;
      else if (id_word != ID_WORD)
        r.status = ST_BAD_ID;
      else if (trl_word != TRAILER_WORD)
        r.status = ST_BAD_TRAILER;
      else if (ver_word != want_version)
        r.status = ST_BAD_VERSION;
      else
        r.status = ST_OK;
      frame_pos   = '0;
      r.roll_raw  = '0;
      r.pitch_raw = '0;
      if (r.status == ST_OK) begin
        valid_count = valid_count + 32'd1;
        r.roll_raw  = roll_word;
        r.pitch_raw = pitch_word;
      end
      r.frames_seen  = seen_count;
      r.frames_valid = valid_count;
      frame_results_q.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_pos    = '0;
      id_word      = '0;
      roll_word    = '0;
      pitch_word   = '0;
      ver_word     = '0;
      trl_word     = '0;
      seen_count   = '0;
      valid_count  = '0;
      want_version = '0;
      frame_results_q.delete();
    end else begin
      // A result is registered behind its idle item, so the output side is
      // checked before this edge's input is absorbed.
      if (out_valid && !out_stall) begin
        got.status       = out_status;
        got.roll_raw     = out_roll_raw;
        got.pitch_raw    = out_pitch_raw;
        got.frames_seen  = out_frames_seen;
        got.frames_valid = out_frames_valid;
        if (frame_results_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: status=%0d roll=%0d pitch=%0d seen=%0d valid=%0d",
                   $time, got.status, got.roll_raw, got.pitch_raw, got.frames_seen,
                   got.frames_valid);
        end else begin
          want = frame_results_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch: expected status=%0d roll=%0d pitch=%0d seen=%0d valid=%0d",
                     $time, want.status, want.roll_raw, want.pitch_raw, want.frames_seen,
                     want.frames_valid);
            $display("%0t:           actual status=%0d roll=%0d pitch=%0d seen=%0d valid=%0d",
                     $time, got.status, got.roll_raw, got.pitch_raw, got.frames_seen,
                     got.frames_valid);
          end
        end
      end
      if (cfg_wr_en)
        want_version = cfg_wr_data;
      if (in_valid && !in_stall)
        absorb_item(in_req_type[0], in_rx_byte);
    end
    pending = frame_results_q.size();
  end

endmodule

@@ tb/sv/idle_delimited_sensor_frame_parser_tb.sv @@
// ----------------------------------------------------------------------------
// idle_delimited_sensor_frame_parser_tb
// Drives byte and idle items into the frame parser: a directed set of frames
// covering every check and corner, then random frames over several version
// settings with random idling on both channels. The checker reports failures.
// ----------------------------------------------------------------------------
module idle_delimited_sensor_frame_parser_tb;
  import isfp_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [15:0]        cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [0:0]         in_req_type;
  logic [7:0]         in_rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_status;
  logic signed [15:0] out_roll_raw;
  logic signed [15:0] out_pitch_raw;
  logic [31:0]        out_frames_seen;
  logic [31:0]        out_frames_valid;

  int errors;
  int pending;

  int          gap_pct;
  int          stall_pct;
  int          stall_left;
  int          n_items;
  logic        frame_open;
  logic [15:0] cur_version;

  idle_delimited_sensor_frame_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_roll_raw     (out_roll_raw),
    .out_pitch_raw    (out_pitch_raw),
    .out_frames_seen  (out_frames_seen),
    .out_frames_valid (out_frames_valid)
  );

  isfp_frame_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_roll_raw     (out_roll_raw),
    .out_pitch_raw    (out_pitch_raw),
    .out_frames_seen  (out_frames_seen),
    .out_frames_valid (out_frames_valid),
    .errors           (errors),
    .pending          (pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Receiver stalls come in bursts of random length, each started with a chance of stall_pct percent.
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall  = 1'b1;
        stall_left = stall_left - 1;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall  = 1'b1;
        stall_left = $urandom_range(0, 6);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL idle_delimited_sensor_frame_parser");
    $finish;
  end

  task automatic send_item(input logic req, input logic [7:0] b);
    int gap;
    gap = 0;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
      gap = $urandom_range(1, 7);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    in_valid    = 1'b1;
    in_req_type = req;
    in_rx_byte  = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (req == REQ_BYTE) begin
      n_items++;
      frame_open = 1'b1;
    end else if (frame_open) begin
      n_items++;
      frame_open = 1'b0;
    end
  endtask

  // Sends len bytes with the given words at their fixed positions and random
  // filler elsewhere, then the idle item that closes the frame.
  task automatic send_frame(input int len, input logic [15:0] id, input logic [15:0] roll,
                            input logic [15:0] pitch, input logic [15:0] ver,
                            input logic [15:0] trl);
    logic [7:0] b;
    for (int p = 0; p < len; p++) begin
      b = 8'($urandom);
      case (POS_W'(p))
        POS_ID_LO:    b = id[7:0];
        POS_ID_HI:    b = id[15:8];
        POS_ROLL_LO:  b = roll[7:0];
        POS_ROLL_HI:  b = roll[15:8];
        POS_PITCH_LO: b = pitch[7:0];
        POS_PITCH_HI: b = pitch[15:8];
        POS_VER_LO:   b = ver[7:0];
        POS_VER_HI:   b = ver[15:8];
        POS_TRL_LO:   b = trl[7:0];
        POS_TRL_HI:   b = trl[15:8];
        default: ;
      endcase
      send_item(REQ_BYTE, b);
    end
    send_item(REQ_IDLE, 8'($urandom));
  endtask

  // Holds the input until every result is out, then waits out any byte still
  // in flight before the register may change.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_version(input logic [15:0] v);
    drain_results();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    cur_version = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Mostly well-formed frames with occasional damage, plus short and
  // overlong noise frames and stray idle items.
  task automatic random_frame();
    int          pick;
    int          len;
    logic [15:0] id;
    logic [15:0] ver;
    logic [15:0] trl;
    pick = $urandom_range(0, 99);
    if (pick < 72)
      len = int'(FRAME_BYTES);
    else if (pick < 80)
      len = $urandom_range(52, 56);
    else if (pick < 94)
      len = $urandom_range(1, 6);
    else
      len = $urandom_range(57, 200);
    id  = ($urandom_range(0, 99) < 85) ? ID_WORD : 16'($urandom);
    trl = ($urandom_range(0, 99) < 85) ? TRAILER_WORD : 16'($urandom);
    ver = ($urandom_range(0, 99) < 80) ? cur_version : 16'($urandom);
    send_frame(len, id, 16'($urandom), 16'($urandom), ver, trl);
    if ($urandom_range(0, 9) == 0)
      send_item(REQ_IDLE, 8'($urandom));
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_req_type = REQ_BYTE;
    in_rx_byte  = '0;
    gap_pct     = 0;
    stall_pct   = 0;
    n_items     = 0;
    frame_open  = 1'b0;
    cur_version = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed frames, first with the version left at its reset value.
    gap_pct   = 15;
    stall_pct = 15;
    send_item(REQ_IDLE, 8'hFF);
    send_frame(int'(FRAME_BYTES), ID_WORD, 16'h8000, 16'h7FFF, 16'h0000, TRAILER_WORD);
    send_item(REQ_IDLE, 8'h00);
    send_frame(1, 16'h00FF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_frame(int'(FRAME_BYTES) - 1, ID_WORD, 16'h1234, 16'h5678, 16'h0000, TRAILER_WORD);
    send_frame(int'(FRAME_BYTES) + 1, ID_WORD, 16'h1234, 16'h5678, 16'h0000, TRAILER_WORD);
    send_frame(BUFFER_LIMIT + 12, ID_WORD, 16'h0001, 16'h0002, 16'h0000, TRAILER_WORD);
    send_frame(int'(FRAME_BYTES), 16'h5557, 16'h0001, 16'h0002, 16'h0000, TRAILER_WORD);
    send_frame(int'(FRAME_BYTES), 16'h5458, 16'h0001, 16'h0002, 16'h0000, TRAILER_WORD);
    send_frame(int'(FRAME_BYTES), ID_WORD, 16'h0001, 16'h0002, 16'h0000, 16'h0B0D);
    send_frame(int'(FRAME_BYTES), ID_WORD, 16'h0001, 16'h0002, 16'h0001, TRAILER_WORD);
    // Several checks fail at once; the earliest check decides the status.
    send_frame(int'(FRAME_BYTES), 16'h0000, 16'h0001, 16'h0002, 16'hFFFF, 16'hFFFF);
    send_frame(int'(FRAME_BYTES), ID_WORD, 16'h0001, 16'h0002, 16'hFFFF, 16'h0000);
    write_version(16'hFFFF);
    send_frame(int'(FRAME_BYTES), ID_WORD, 16'h7FFF, 16'h8000, 16'hFFFF, TRAILER_WORD);
    // A short frame leaves stale captured words behind; a full frame rewrites them.
    send_frame(40, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h0000, 16'h0000);
    send_frame(int'(FRAME_BYTES), ID_WORD, 16'hFFFF, 16'h0000, 16'hFFFF, TRAILER_WORD);
    send_frame(int'(FRAME_BYTES), ID_WORD, 16'h0000, 16'hFFFF, 16'h0000, TRAILER_WORD);

    // Random frames over several version settings; the last phase runs
    // without idling on either side.
    n_items = 0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_version(16'h0000);
        1: write_version(16'hFFFF);
        default: write_version(16'($urandom));
      endcase
      case (ph)
        0: begin gap_pct = 20; stall_pct = 20; end
        1: begin gap_pct = 50; stall_pct = 5;  end
        2: begin gap_pct = 5;  stall_pct = 60; end
        3: begin gap_pct = 30; stall_pct = 30; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      while (n_items < (ph + 1) * 170)
        random_frame();
    end

    drain_results();
    repeat (10) @(negedge clk);
    if (errors == 0)
      $display("PASS idle_delimited_sensor_frame_parser");
    else
      $display("FAIL idle_delimited_sensor_frame_parser");
    $finish;
  end

endmodule

@@ sim.f @@
design/isfp_pkg.sv
design/isfp_capture.sv
design/idle_delimited_sensor_frame_parser.sv
tb/sv/isfp_frame_checker.sv
tb/sv/idle_delimited_sensor_frame_parser_tb.sv
